/* src/wsfg_pkg.sv */
// ----------------------------------------------------------------------------
// wsfg_pkg: shared types and constants of the WebSocket frame generator
// Queue entry layout, length encodings, register indexes and key byte select.
// ----------------------------------------------------------------------------
package wsfg_pkg;

    localparam int LEN_W      = 31;
    localparam int KEY_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int IDX_W      = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_FLAGS  = 2'd0;
    localparam logic [1:0] CFG_OPCODE = 2'd1;
    localparam logic [1:0] CFG_MASK   = 2'd2;
    localparam logic [1:0] CFG_KEY    = 2'd3;

    // payload length encodings of the second header byte
    localparam logic [1:0] LEN_SHORT = 2'd0;
    localparam logic [1:0] LEN_16    = 2'd1;
    localparam logic [1:0] LEN_64    = 2'd2;

    localparam logic [6:0] CODE_16 = 7'h7E;
    localparam logic [6:0] CODE_64 = 7'h7F;

    typedef struct packed {
        logic             is_hdr;
        logic [7:0]       byte0;    // header first byte, or finished payload byte
        logic [LEN_W-1:0] len;
        logic [1:0]       len_sel;
        logic             mask_en;
        logic [KEY_W-1:0] key;
        logic             done;
        logic             err;
    } t_entry;

    function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                            input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

/* src/wsfg_front.sv */
// ----------------------------------------------------------------------------
// wsfg_front: item classifier
// Takes start and payload items, tracks frame progress and mask phase, and
// pushes one descriptor per item into the queue.
// ----------------------------------------------------------------------------
module wsfg_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_full,
    input  logic                       i_op,
    input  logic [wsfg_pkg::LEN_W-1:0] i_payload_length,
    input  logic [7:0]                 i_data_byte,
    input  logic [3:0]                 i_frame_flags,
    input  logic [3:0]                 i_frame_opcode,
    input  logic                       i_mask_enable,
    input  logic [wsfg_pkg::KEY_W-1:0] i_mask_key,
    output logic                       o_push,
    output wsfg_pkg::t_entry           o_entry
);
    import wsfg_pkg::*;

    logic [LEN_W-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]       r_mask_phase, n_mask_phase;
    logic             w_accept;

    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    always_comb begin
        o_entry         = '0;
        o_entry.mask_en = i_mask_enable;
        o_entry.key     = i_mask_key;
        o_entry.len     = i_payload_length;
        n_bytes_left    = r_bytes_left;
        n_mask_phase    = r_mask_phase;
        if (!i_op) begin
            o_entry.is_hdr = 1'b1;
            o_entry.byte0  = {i_frame_flags, i_frame_opcode};
            o_entry.done   = (i_payload_length == '0);
            if (i_payload_length > LEN_W'(32'hFFFF)) begin
                o_entry.len_sel = LEN_64;
            end else if (i_payload_length >= LEN_W'(32'h7E)) begin
                o_entry.len_sel = LEN_16;
            end else begin
                o_entry.len_sel = LEN_SHORT;
            end
            n_bytes_left = i_payload_length;
            n_mask_phase = 2'd0;
        end else if (r_bytes_left == '0) begin
            // overrun: zero byte, flag it, leave state alone
            o_entry.err = 1'b1;
        end else begin
            o_entry.byte0 = i_data_byte ^
                            (i_mask_enable ? key_byte(i_mask_key, r_mask_phase) : 8'h00);
            o_entry.done  = (r_bytes_left == LEN_W'(1));
            n_bytes_left  = r_bytes_left - LEN_W'(1);
            n_mask_phase  = r_mask_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_mask_phase <= '0;
        end else if (w_accept) begin
            r_bytes_left <= n_bytes_left;
            r_mask_phase <= n_mask_phase;
        end
    end

endmodule

/* src/wsfg_queue.sv */
// ----------------------------------------------------------------------------
// wsfg_queue: descriptor queue
// Small FIFO between classifier and byte writer so each side stalls alone.
// ----------------------------------------------------------------------------
module wsfg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsfg_pkg::t_entry i_entry,
    input  logic             i_pop,
    output wsfg_pkg::t_entry o_entry,
    output logic             o_empty,
    output logic             o_full
);
    import wsfg_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

/* src/wsfg_back.sv */
// ----------------------------------------------------------------------------
// wsfg_back: byte writer
// Pops descriptors and sends one frame byte per transaction through an
// output register; header descriptors expand into 2 to 14 bytes.
// ----------------------------------------------------------------------------
module wsfg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wsfg_pkg::t_entry i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_frame_done,
    output logic             o_overrun_error
);
    import wsfg_pkg::*;

    function automatic logic [IDX_W-1:0] ext_count(input t_entry e);
        logic [IDX_W-1:0] n;
        unique case (e.len_sel)
            LEN_16:  n = IDX_W'(2);
            LEN_64:  n = IDX_W'(8);
            default: n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] last_idx(input t_entry e);
        return IDX_W'(1) + ext_count(e) + (e.mask_en ? IDX_W'(4) : IDX_W'(0));
    endfunction

    function automatic logic [7:0] hdr_byte(input t_entry e, input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] ext;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic [7:0]       b;
        ext = ext_count(e);
        j   = idx - IDX_W'(2);
        k   = j - ext;
        if (idx == IDX_W'(1)) begin
            unique case (e.len_sel)
                LEN_16:  b = {e.mask_en, CODE_16};
                LEN_64:  b = {e.mask_en, CODE_64};
                default: b = {e.mask_en, e.len[6:0]};
            endcase
        end else if (j < ext) begin
            if (e.len_sel == LEN_64) begin
                unique case (j[2:0])
                    3'd4:    b = {1'b0, e.len[30:24]};
                    3'd5:    b = e.len[23:16];
                    3'd6:    b = e.len[15:8];
                    3'd7:    b = e.len[7:0];
                    default: b = 8'h00;
                endcase
            end else begin
                b = j[0] ? e.len[7:0] : e.len[15:8];
            end
        end else begin
            b = key_byte(e.key, k[1:0]);
        end
        return b;
    endfunction

    t_entry           r_cur, n_cur;
    logic             r_hdr_act, n_hdr_act;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;
    logic             r_done, n_done;
    logic             r_err, n_err;
    logic             w_advance;
    logic             w_end;

    assign w_advance = !r_valid || !i_stall;
    assign w_end     = (r_idx == last_idx(r_cur));

    always_comb begin
        n_cur     = r_cur;
        n_hdr_act = r_hdr_act;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_byte    = r_byte;
        n_last    = r_last;
        n_done    = r_done;
        n_err     = r_err;
        o_pop     = 1'b0;
        if (w_advance) begin
            if (r_hdr_act) begin
                n_valid = 1'b1;
                n_byte  = hdr_byte(r_cur, r_idx);
                n_last  = w_end;
                n_done  = w_end && r_cur.done;
                n_err   = 1'b0;
                n_idx   = r_idx + IDX_W'(1);
                if (w_end) begin
                    n_hdr_act = 1'b0;
                end
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_byte  = i_entry.byte0;
                if (i_entry.is_hdr) begin
                    n_last    = 1'b0;
                    n_done    = 1'b0;
                    n_err     = 1'b0;
                    n_cur     = i_entry;
                    n_hdr_act = 1'b1;
                    n_idx     = IDX_W'(1);
                end else begin
                    n_last = 1'b1;
                    n_done = i_entry.done;
                    n_err  = i_entry.err;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_idx  <= n_idx;
        r_byte <= n_byte;
        r_last <= n_last;
        r_done <= n_done;
        r_err  <= n_err;
        if (!i_rst_n) begin
            r_hdr_act <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_hdr_act <= n_hdr_act;
            r_valid   <= n_valid;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_run_last      = r_last;
    assign o_frame_done    = r_done;
    assign o_overrun_error = r_err;

endmodule

/* src/websocket_frame_generator.sv */
// ----------------------------------------------------------------------------
// websocket_frame_generator: RFC 6455 frame writer
// Emits frame headers and masked payload bytes, one byte per transaction.
// ----------------------------------------------------------------------------
// A start item (op 0) produces the whole header: 2 to 14 bytes, sent one per
// clock unless stalled. A payload item (op 1) produces one byte and streams at
// one item per clock unless the queue is full. The output byte register sets
// the pace of one byte per cycle unless stalled; a four-deep descriptor queue
// lets input items keep arriving while a header is still being sent, and input
// stall rises only when that queue is full. Registers are meant to be written
// while the block is idle; the config port is always ready.
module websocket_frame_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  logic [wsfg_pkg::LEN_W-1:0] i_payload_length,
    input  logic [7:0]                 i_data_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_run_last,
    output logic                       o_frame_done,
    output logic                       o_overrun_error,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [31:0]                i_cfg_data
);
    import wsfg_pkg::*;

    logic [3:0]       r_frame_flags;
    logic [3:0]       r_frame_opcode;
    logic             r_mask_enable;
    logic [KEY_W-1:0] r_mask_key;

    logic   w_push, w_pop, w_empty, w_full;
    t_entry w_push_entry, w_pop_entry;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_flags  <= 4'h8;
            r_frame_opcode <= 4'h1;
            r_mask_enable  <= 1'b0;
            r_mask_key     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FLAGS:  r_frame_flags  <= i_cfg_data[3:0];
                CFG_OPCODE: r_frame_opcode <= i_cfg_data[3:0];
                CFG_MASK:   r_mask_enable  <= i_cfg_data[0];
                CFG_KEY:    r_mask_key     <= i_cfg_data[KEY_W-1:0];
            endcase
        end
    end

    wsfg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_full           (w_full),
        .i_op             (i_op),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .i_frame_flags    (r_frame_flags),
        .i_frame_opcode   (r_frame_opcode),
        .i_mask_enable    (r_mask_enable),
        .i_mask_key       (r_mask_key),
        .o_push           (w_push),
        .o_entry          (w_push_entry)
    );

    wsfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    wsfg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (w_pop_entry),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_frame_done    (o_frame_done),
        .o_overrun_error (o_overrun_error)
    );

endmodule

/* tb/websocket_frame_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_generator_tb: self-checking bench for the frame writer
// A directed table walks header-length boundaries, masking, overrun and
// mid-frame register changes, then random frames run under several idle and
// stall mixes plus a long receiver hold. Every output byte is checked against
// an in-bench frame encoder or, for some directed rows, hand-written bytes.
// ----------------------------------------------------------------------------
module websocket_frame_generator_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int LW = wsfg_pkg::LEN_W;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } t_op;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       done;
        logic       err;
    } t_frame_byte;

    typedef struct packed {
        logic          is_cfg;
        logic [1:0]    reg_idx;
        logic [31:0]   reg_val;
        logic          op;
        logic [LW-1:0] len;
        logic [7:0]    dat;
        logic [3:0]    n_known;
    } t_stim_row;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic          i_op = OP_START;
    logic [LW-1:0] i_payload_length = '0;
    logic [7:0]    i_data_byte = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [7:0]    o_out_byte;
    logic          o_run_last;
    logic          o_frame_done;
    logic          o_overrun_error;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    // encoder copy of the registers and frame state
    logic [3:0]    reg_flags = 4'h8;
    logic [3:0]    reg_opcode = 4'h1;
    logic          reg_mask_en = 1'b0;
    logic [31:0]   reg_key = '0;
    logic [1:0]    key_phase = '0;
    logic [LW-1:0] bytes_remaining = '0;

    // queues fill at the front and drain from the back
    t_frame_byte   expected_bytes[$];
    t_frame_byte   known_bytes[$];
    t_stim_row     stim_table[$];

    int            drv_n_known = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    int            items_sent = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            hold_reqs = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    websocket_frame_generator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_payload_length(i_payload_length),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_frame_done    (o_frame_done),
        .o_overrun_error (o_overrun_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last, input logic done,
                             input logic err, input bit keep);
        t_frame_byte fb;
        fb.byte_val = b;
        fb.last = last;
        fb.done = done;
        fb.err = err;
        if (keep)
            expected_bytes.push_front(fb);
    endtask

    // Encode one input transaction; update frame state always, queue the
    // bytes only when keep is set.
    task automatic encode_item(input logic op, input logic [LW-1:0] len,
                               input logic [7:0] dat, input bit keep);
        logic [7:0] hdr [0:13];
        logic [7:0] mbit;
        logic [7:0] d;
        int         n;
        n = 0;
        mbit = reg_mask_en ? 8'h80 : 8'h00;
        if (op == OP_START) begin
            hdr[n] = {reg_flags, reg_opcode};
            n++;
            if (len > 31'h0000_FFFF) begin
                hdr[n] = mbit | 8'h7F;
                n++;
                repeat (4) begin
                    hdr[n] = 8'h00;
                    n++;
                end
                hdr[n] = {1'b0, len[30:24]};
                n++;
                hdr[n] = len[23:16];
                n++;
                hdr[n] = len[15:8];
                n++;
                hdr[n] = len[7:0];
                n++;
            end else if (len >= 31'd126) begin
                hdr[n] = mbit | 8'h7E;
                n++;
                hdr[n] = len[15:8];
                n++;
                hdr[n] = len[7:0];
                n++;
            end else begin
                hdr[n] = mbit | {1'b0, len[6:0]};
                n++;
            end
            if (reg_mask_en) begin
                hdr[n] = reg_key[31:24];
                n++;
                hdr[n] = reg_key[23:16];
                n++;
                hdr[n] = reg_key[15:8];
                n++;
                hdr[n] = reg_key[7:0];
                n++;
            end
            bytes_remaining = len;
            key_phase = '0;
            for (int k = 0; k < n; k++)
                push_byte(hdr[k], k == n - 1, (k == n - 1) && (len == 0), 1'b0, keep);
        end else if (bytes_remaining == 0) begin
            push_byte(8'h00, 1'b1, 1'b0, 1'b1, keep);
        end else begin
            d = dat;
            if (reg_mask_en)
                d = d ^ reg_key[31 - 8 * key_phase -: 8];
            key_phase = key_phase + 2'd1;
            bytes_remaining = bytes_remaining - 1'b1;
            push_byte(d, 1'b1, bytes_remaining == 0, 1'b0, keep);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_byte got;
        t_frame_byte want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    wsfg_pkg::CFG_FLAGS:  reg_flags = i_cfg_data[3:0];
                    wsfg_pkg::CFG_OPCODE: reg_opcode = i_cfg_data[3:0];
                    wsfg_pkg::CFG_MASK:   reg_mask_en = i_cfg_data[0];
                    wsfg_pkg::CFG_KEY:    reg_key = i_cfg_data;
                endcase
            end
            if (i_valid && !o_stall) begin
                encode_item(i_op, i_payload_length, i_data_byte, drv_n_known == 0);
                repeat (drv_n_known) expected_bytes.push_front(known_bytes.pop_back());
            end
            if (o_valid && !i_stall) begin
                got.byte_val = o_out_byte;
                got.last = o_run_last;
                got.done = o_frame_done;
                got.err = o_overrun_error;
                if (expected_bytes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %h", got.byte_val));
                end else begin
                    want = expected_bytes.pop_back();
                    if (got.byte_val !== want.byte_val || got.last !== want.last ||
                        got.done !== want.done || got.err !== want.err)
                        flag_mismatch($sformatf(
                            "byte %h/%h last %b/%b done %b/%b err %b/%b (got/exp)",
                            got.byte_val, want.byte_val, got.last, want.last,
                            got.done, want.done, got.err, want.err));
                end
            end
        end
    end

    // Offer one item and hold it until accepted; valid stays high on return.
    task automatic send_item(input logic op, input logic [LW-1:0] len,
                             input logic [7:0] dat, input int n_known);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_payload_length <= len;
        i_data_byte <= dat;
        drv_n_known <= n_known;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic wait_for_idle;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic randomize_regs;
        logic [31:0] key;
        case ($urandom_range(0, 3))
            0:       key = 32'h0000_0000;
            1:       key = 32'hFFFF_FFFF;
            default: key = $urandom;
        endcase
        write_reg(wsfg_pkg::CFG_FLAGS, ($urandom_range(0, 3) == 0) ? 32'hF : $urandom_range(0, 15));
        write_reg(wsfg_pkg::CFG_OPCODE, ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 15));
        write_reg(wsfg_pkg::CFG_MASK, $urandom_range(0, 1));
        write_reg(wsfg_pkg::CFG_KEY, key);
    endtask

    // One well-formed frame with random content; sometimes cut short, given
    // an extra byte, or reconfigured part way through.
    task automatic send_frame(input bit allow_cfg);
        logic [LW-1:0] len;
        int            n_bytes;
        int            cut;
        case ($urandom_range(0, 19))
            0, 1:    len = LW'($urandom_range(126, 400));
            2:       len = ($urandom_range(0, 1) != 0) ? 31'd65535 : 31'd65536;
            3, 4:    len = LW'($urandom);
            default: len = LW'($urandom_range(0, 9));
        endcase
        n_bytes = (len > 12) ? $urandom_range(0, 6) : int'(len);
        if ($urandom_range(0, 6) == 0)
            n_bytes++;
        cut = (allow_cfg && $urandom_range(0, 9) == 0) ? $urandom_range(0, n_bytes) : -1;
        send_item(OP_START, len, 8'($urandom_range(0, 255)), 0);
        for (int k = 0; k < n_bytes; k++) begin
            if (k == cut) begin
                wait_for_idle();
                write_reg(wsfg_pkg::CFG_MASK, $urandom_range(0, 1));
                write_reg(wsfg_pkg::CFG_KEY, $urandom);
            end
            send_item(OP_PAYLOAD, LW'($urandom), 8'($urandom_range(0, 255)), 0);
        end
    endtask

    task automatic run_phase(input int n_items, input bit allow_cfg);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0)
                send_item(t_op'($urandom_range(0, 1)), LW'($urandom),
                          8'($urandom_range(0, 255)), 0);
            else
                send_frame(allow_cfg);
            if (allow_cfg && $urandom_range(0, 7) == 0) begin
                wait_for_idle();
                randomize_regs();
            end
        end
    endtask

    task automatic add_item(input logic op, input logic [LW-1:0] len, input logic [7:0] dat,
                            input int n_known);
        t_stim_row r;
        r = '0;
        r.op = op;
        r.len = len;
        r.dat = dat;
        r.n_known = 4'(n_known);
        stim_table.push_front(r);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        stim_table.push_front(r);
    endtask

    task automatic add_known(input logic [7:0] b, input logic last, input logic done,
                             input logic err);
        t_frame_byte fb;
        fb.byte_val = b;
        fb.last = last;
        fb.done = done;
        fb.err = err;
        known_bytes.push_front(fb);
    endtask

    initial begin
        t_stim_row row;
        // reset values: FIN set, text opcode, no masking
        add_item(OP_START, 31'd0, 8'h00, 2);
        add_known(8'h81, 1'b0, 1'b0, 1'b0);
        add_known(8'h00, 1'b1, 1'b1, 1'b0);
        add_item(OP_PAYLOAD, 31'd0, 8'hFF, 1);
        add_known(8'h00, 1'b1, 1'b0, 1'b1);
        add_item(OP_START, 31'd125, 8'h00, 2);
        add_known(8'h81, 1'b0, 1'b0, 1'b0);
        add_known(8'h7D, 1'b1, 1'b0, 1'b0);
        add_item(OP_PAYLOAD, 31'd0, 8'h00, 0);
        add_item(OP_PAYLOAD, 31'h7FFF_FFFF, 8'hFF, 0);
        add_item(OP_START, 31'd126, 8'hFF, 4);
        add_known(8'h81, 1'b0, 1'b0, 1'b0);
        add_known(8'h7E, 1'b0, 1'b0, 1'b0);
        add_known(8'h00, 1'b0, 1'b0, 1'b0);
        add_known(8'h7E, 1'b1, 1'b0, 1'b0);
        add_item(OP_START, 31'd65535, 8'h00, 4);
        add_known(8'h81, 1'b0, 1'b0, 1'b0);
        add_known(8'h7E, 1'b0, 1'b0, 1'b0);
        add_known(8'hFF, 1'b0, 1'b0, 1'b0);
        add_known(8'hFF, 1'b1, 1'b0, 1'b0);
        add_item(OP_START, 31'd65536, 8'h00, 0);
        add_item(OP_START, 31'h7FFF_FFFF, 8'h00, 0);
        add_item(OP_START, 31'd1, 8'h00, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'hA5, 1);
        add_known(8'hA5, 1'b1, 1'b1, 1'b0);
        add_item(OP_PAYLOAD, 31'd0, 8'h5A, 1);
        add_known(8'h00, 1'b1, 1'b0, 1'b1);
        // all flags, opcode zero, masking on: key wraps after four bytes
        add_cfg(wsfg_pkg::CFG_FLAGS, 32'hF);
        add_cfg(wsfg_pkg::CFG_OPCODE, 32'h0);
        add_cfg(wsfg_pkg::CFG_MASK, 32'h1);
        add_cfg(wsfg_pkg::CFG_KEY, 32'hDEAD_BEEF);
        add_item(OP_START, 31'd5, 8'h00, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'h00, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'hFF, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'h55, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'hAA, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'h0F, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'h33, 0);
        add_cfg(wsfg_pkg::CFG_FLAGS, 32'h0);
        add_cfg(wsfg_pkg::CFG_OPCODE, 32'hF);
        add_cfg(wsfg_pkg::CFG_KEY, 32'hFFFF_FFFF);
        add_item(OP_START, 31'd0, 8'h00, 0);
        add_item(OP_START, 31'd4, 8'h00, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'h12, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'h34, 0);
        // unmask the rest of the frame
        add_cfg(wsfg_pkg::CFG_MASK, 32'h0);
        add_item(OP_PAYLOAD, 31'd0, 8'h56, 0);
        add_item(OP_PAYLOAD, 31'd0, 8'h78, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // oldest row sits at the back
        while (stim_table.size() != 0) begin
            row = stim_table.pop_back();
            if (row.is_cfg) begin
                wait_for_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.op, row.len, row.dat, int'(row.n_known));
            end
        end

        wait_for_idle();
        randomize_regs();
        run_phase(40, 1'b1);

        send_idle_pct = 58;
        run_phase(40, 1'b1);

        send_idle_pct = 0;
        stall_pct <= 58;
        run_phase(40, 1'b1);

        send_idle_pct = 32;
        stall_pct <= 32;
        run_phase(40, 1'b1);

        // hold the output long enough for the descriptor queue to fill
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_reqs <= hold_reqs + 1;
        run_phase(40, 1'b0);

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0)
            flag_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* websocket_frame_generator.f */
src/wsfg_pkg.sv
src/wsfg_front.sv
src/wsfg_queue.sv
src/wsfg_back.sv
src/websocket_frame_generator.sv
tb/websocket_frame_generator_tb.sv
